// ----- rtl/ctbd_pkg.sv -----
`default_nettype none

package ctbd_pkg;

	localparam logic [31:0] RAM_BASE_DEF       = 32'h8000_0000;
	localparam int          RAM_ADDR_BITS_DEF  = 26;
	localparam logic [11:0] CLINT_MEGABYTE_DEF = 12'd272;

	localparam int          CLINT_OFS_BITS = 20;
	localparam logic [19:0] MTIMECMP_OFS   = 20'h04000;
	localparam logic [19:0] MTIME_OFS      = 20'h0BFF8;
	localparam logic [19:0] MSIP_OFS       = 20'h00000;
	localparam logic [3:0]  CLINT_REG_SIZE = 4'd4;

	typedef enum logic [2:0] {
		OP_READ   = 3'd0,
		OP_FETCH  = 3'd1,
		OP_ATOMIC = 3'd2,
		OP_WRITE  = 3'd3,
		OP_TICK   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_RAM   = 3'd0,
		ST_CLINT = 3'd1,
		ST_LMIS  = 3'd2,
		ST_SMIS  = 3'd3,
		ST_LFLT  = 3'd4,
		ST_XFLT  = 3'd5,
		ST_SFLT  = 3'd6,
		ST_UNSUP = 3'd7
	} status_t;

	// Decoded view of one item, handed from the decoder to the timer logic.
	typedef struct packed {
		status_t     status;
		logic [25:0] ram_offset;
		logic        tick;
		logic        writes;
		logic        cmp_hit;
		logic        time_hit;
		logic        hi;
	} dec_t;

	function automatic logic [63:0] put_half(input logic [63:0] cur, input logic hi,
			input logic [31:0] data);
		logic [63:0] res;
		res = cur;
		if (hi) begin
			res[63:32] = data;
		end else begin
			res[31:0] = data;
		end
		return res;
	endfunction

	function automatic status_t fault_code(input logic [2:0] op);
		status_t res;
		case (op)
			OP_READ:  res = ST_LFLT;
			OP_FETCH: res = ST_XFLT;
			default:  res = ST_SFLT;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ctbd_decode.sv -----
`default_nettype none

module ctbd_decode #(
	parameter logic [31:0] RAM_BASE       = ctbd_pkg::RAM_BASE_DEF,
	parameter int          RAM_ADDR_BITS  = ctbd_pkg::RAM_ADDR_BITS_DEF,
	parameter logic [11:0] CLINT_MEGABYTE = ctbd_pkg::CLINT_MEGABYTE_DEF
) (
	input  wire logic [2:0]     op,
	input  wire logic [63:0]    addr,
	input  wire logic [3:0]     size,
	input  wire logic [31:0]    wdata,
	output ctbd_pkg::dec_t      dec
);
	import ctbd_pkg::*;

	localparam logic [RAM_ADDR_BITS:0] SPAN = {1'b1, {RAM_ADDR_BITS{1'b0}}};

	logic [3:0]               size_m1;
	logic                     misaligned;
	logic                     clint_mb;
	logic [CLINT_OFS_BITS-1:0] ofs;
	logic                     size4;
	logic [63:0]              off;
	logic [RAM_ADDR_BITS:0]   end_sum;
	logic                     ram_fault;

	always_comb begin
		size_m1 = size - 4'd1;
		// A zero size masks with all ones, so any nonzero address is misaligned.
		misaligned = (size == 4'd0) ? (addr != 64'd0) : ((addr[3:0] & size_m1) != 4'd0);
		clint_mb   = (addr[63:CLINT_OFS_BITS] == 44'(CLINT_MEGABYTE));
		ofs        = addr[CLINT_OFS_BITS-1:0];
		size4      = (size == CLINT_REG_SIZE);
		off        = addr - {32'd0, RAM_BASE};
		end_sum    = {1'b0, off[RAM_ADDR_BITS-1:0]} + (RAM_ADDR_BITS+1)'(size);
		ram_fault  = (off[63:RAM_ADDR_BITS] != '0) || (end_sum > SPAN);

		dec.status     = ST_CLINT;
		dec.ram_offset = '0;
		dec.tick       = 1'b0;
		dec.writes     = (op == OP_ATOMIC) || (op == OP_WRITE);
		dec.cmp_hit    = 1'b0;
		dec.time_hit   = 1'b0;
		dec.hi         = ofs[2];

		if (op == OP_TICK) begin
			dec.tick = 1'b1;
		end else if (op > OP_TICK) begin
			dec.status = ST_UNSUP;
		end else if (misaligned && op != OP_FETCH) begin
			dec.status = (op == OP_READ) ? ST_LMIS : ST_SMIS;
		end else if (clint_mb) begin
			if (ofs[19:3] == MTIMECMP_OFS[19:3] && size4) begin
				dec.cmp_hit = 1'b1;
			end else if (ofs[19:3] == MTIME_OFS[19:3] && size4) begin
				dec.time_hit = 1'b1;
			end else if (ofs == MSIP_OFS && size4) begin
				if (dec.writes && wdata != 32'd0) begin
					dec.status = ST_UNSUP;
				end
			end else begin
				dec.status = fault_code(op);
			end
		end else if (ram_fault) begin
			dec.status = fault_code(op);
		end else begin
			dec.status     = ST_RAM;
			dec.ram_offset = off[25:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/clint_timer_bus_decoder.sv -----
`default_nettype none

// CLINT timer and bus address decoder. Each input item is one bus access
// (read, fetch, atomic, write) or one timer tick and yields exactly one result
// item. The block takes one item per clock unless the output stalls:
// an input register feeds a single pass of decode and timer update, and a
// result register holds the answer, so a new item is accepted while the
// previous result still waits. The 64-bit mtime/mtimecmp update and compare
// in that pass set the clock period. Results report the RAM offset or the
// CLINT register half that was read, and the timer-pending flag after the item.
module clint_timer_bus_decoder #(
	parameter logic [31:0] RAM_BASE       = ctbd_pkg::RAM_BASE_DEF,
	parameter int          RAM_ADDR_BITS  = ctbd_pkg::RAM_ADDR_BITS_DEF,
	parameter logic [11:0] CLINT_MEGABYTE = ctbd_pkg::CLINT_MEGABYTE_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [103:0] s_axis_tdata,  // addr[63:0], size[67:64], wdata[99:68]
	input  wire logic [2:0]   s_axis_tuser,  // op

	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [63:0]       m_axis_tdata,  // ram_offset[25:0], rdata[57:26],
	                                         // timer_pending[58]
	output logic [2:0]        m_axis_tuser   // status
);
	import ctbd_pkg::*;

	logic        valid_s1;
	logic [2:0]  op_s1;
	logic [63:0] addr_s1;
	logic [3:0]  size_s1;
	logic [31:0] wdata_s1;

	logic        out_free;
	logic        fire;
	dec_t        dec;

	logic [63:0] count_q;
	logic [63:0] cmp_q;
	logic        armed_q;
	logic        pending_q;

	logic [63:0] count_d;
	logic [63:0] cmp_d;
	logic        armed_d;
	logic        pending_d;
	logic        ge;
	logic [31:0] rdata_d;

	logic        m_valid_q;
	status_t     status_q;
	logic [25:0] offset_q;
	logic [31:0] rdata_q;
	logic        tpend_q;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign fire          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1    <= s_axis_tuser;
			addr_s1  <= s_axis_tdata[63:0];
			size_s1  <= s_axis_tdata[67:64];
			wdata_s1 <= s_axis_tdata[99:68];
		end
	end

	ctbd_decode #(
		.RAM_BASE       (RAM_BASE),
		.RAM_ADDR_BITS  (RAM_ADDR_BITS),
		.CLINT_MEGABYTE (CLINT_MEGABYTE)
	) u_decode (
		.op    (op_s1),
		.addr  (addr_s1),
		.size  (size_s1),
		.wdata (wdata_s1),
		.dec   (dec)
	);

	always_comb begin
		count_d   = count_q;
		cmp_d     = cmp_q;
		if (dec.tick) begin
			count_d = count_q + 64'd1;
		end else if (dec.time_hit && dec.writes) begin
			count_d = put_half(count_q, dec.hi, wdata_s1);
		end
		if (dec.cmp_hit && dec.writes) begin
			cmp_d = put_half(cmp_q, dec.hi, wdata_s1);
		end
		ge = (count_d >= cmp_d);

		armed_d   = armed_q;
		pending_d = pending_q;
		if ((dec.cmp_hit || dec.time_hit) && dec.writes) begin
			pending_d = ge;
			armed_d   = !ge;
		end else if (dec.tick && armed_q && ge) begin
			// One-shot compare: fires once, then stays disarmed until rewritten.
			pending_d = 1'b1;
			armed_d   = 1'b0;
		end

		if (dec.cmp_hit) begin
			rdata_d = dec.hi ? cmp_q[63:32] : cmp_q[31:0];
		end else if (dec.time_hit) begin
			rdata_d = dec.hi ? count_q[63:32] : count_q[31:0];
		end else begin
			rdata_d = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			cmp_q     <= '0;
			armed_q   <= 1'b0;
			pending_q <= 1'b0;
		end else if (fire) begin
			count_q   <= count_d;
			cmp_q     <= cmp_d;
			armed_q   <= armed_d;
			pending_q <= pending_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= dec.status;
			offset_q <= dec.ram_offset;
			rdata_q  <= rdata_d;
			tpend_q  <= pending_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {5'd0, tpend_q, rdata_q, offset_q};

`ifndef NO_ASSERTIONS
	// The compare is armed only while the flag is clear.
	a_arm_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(armed_q && pending_q))
		else $error("compare armed while timer pending");

	// A tick never clears a pending flag.
	a_tick_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		fire && dec.tick && pending_q |=> pending_q)
		else $error("tick cleared the pending flag");

	// RAM results never carry register read data.
	a_ram_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && status_q == ST_RAM |-> rdata_q == 32'd0)
		else $error("RAM result with nonzero rdata");
`endif

endmodule

`default_nettype wire

// ----- test/clint_timer_bus_decoder_tb.sv -----
`timescale 1ns / 100ps

module clint_timer_bus_decoder_tb;

	import ctbd_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam int          RANDOM_ITEMS = 750;
	localparam logic [63:0] CLINT_BASE = {32'd0, CLINT_MEGABYTE_DEF, 20'd0};
	localparam logic [63:0] RAM_START = {32'd0, RAM_BASE_DEF};
	localparam logic [63:0] RAM_SPAN = 64'd1 << RAM_ADDR_BITS_DEF;

	typedef struct {
		logic [2:0]  op;
		logic [63:0] addr;
		logic [3:0]  size;
		logic [31:0] wdata;
		bit          typed;
		status_t     status;
		logic [25:0] ofs;
		logic [31:0] rdata;
		logic        pend;
	} access_row_t;

	typedef struct {
		status_t     status;
		logic [25:0] ofs;
		logic [31:0] rdata;
		logic        pend;
	} bus_answer_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata = '0;  // addr[63:0], size[67:64], wdata[99:68]
	logic [2:0]   s_axis_tuser = '0;  // op
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;       // ram_offset[25:0], rdata[57:26], timer_pending[58]
	logic [2:0]   m_axis_tuser;       // status

	// Timer state as the block should hold it.
	logic [63:0] mtime_q = '0;
	logic [63:0] mtimecmp_q = '0;
	logic        cmp_armed = 1'b0;
	logic        irq_pending = 1'b0;

	bus_answer_t answers_due [$];
	access_row_t directed_rows [$];
	int          cycles = 0;
	int          mismatches = 0;
	wire         calm = (cycles >= 300) && (cycles < 550);

	clint_timer_bus_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic access_row_t stim(input logic [2:0] op, input logic [63:0] addr,
			input logic [3:0] size, input logic [31:0] wdata, input bit typed = 1'b0,
			input status_t st = ST_RAM, input logic [25:0] ofs = '0,
			input logic [31:0] rd = '0, input logic pend = 1'b0);
		access_row_t r;
		r.op = op;
		r.addr = addr;
		r.size = size;
		r.wdata = wdata;
		r.typed = typed;
		r.status = st;
		r.ofs = ofs;
		r.rdata = rd;
		r.pend = pend;
		return r;
	endfunction

	function automatic status_t access_fault(input logic [2:0] op);
		if (op == OP_READ) begin
			return ST_LFLT;
		end else if (op == OP_FETCH) begin
			return ST_XFLT;
		end
		return ST_SFLT;
	endfunction

	// After a write to either timer register the flag follows the compare at once;
	// if mtime is still below mtimecmp, a later tick may raise it exactly once.
	task automatic rearm_timer();
		if (mtime_q >= mtimecmp_q) begin
			irq_pending = 1'b1;
			cmp_armed = 1'b0;
		end else begin
			irq_pending = 1'b0;
			cmp_armed = 1'b1;
		end
	endtask

	task automatic predict_answer(input access_row_t r, output bus_answer_t ans);
		logic [63:0] mask;
		logic [63:0] ram_ofs;
		logic [19:0] reg_ofs;
		logic        hi;
		logic        stores;
		ans.status = ST_CLINT;
		ans.ofs = '0;
		ans.rdata = '0;
		stores = (r.op == OP_ATOMIC) || (r.op == OP_WRITE);
		mask = {60'd0, r.size} - 64'd1;
		reg_ofs = r.addr[19:0];
		hi = reg_ofs[2];
		if (r.op == OP_TICK) begin
			mtime_q = mtime_q + 64'd1;
			if (cmp_armed && mtime_q >= mtimecmp_q) begin
				irq_pending = 1'b1;
				cmp_armed = 1'b0;
			end
		end else if (r.op > OP_TICK) begin
			ans.status = ST_UNSUP;
		end else if ((r.addr & mask) != 64'd0 && r.op != OP_FETCH) begin
			ans.status = (r.op == OP_READ) ? ST_LMIS : ST_SMIS;
		end else if (r.addr[63:20] == CLINT_BASE[63:20]) begin
			if (reg_ofs >= MTIMECMP_OFS && reg_ofs < MTIMECMP_OFS + 20'd8
					&& r.size == CLINT_REG_SIZE) begin
				ans.rdata = hi ? mtimecmp_q[63:32] : mtimecmp_q[31:0];
				if (stores) begin
					if (hi) begin
						mtimecmp_q[63:32] = r.wdata;
					end else begin
						mtimecmp_q[31:0] = r.wdata;
					end
					rearm_timer();
				end
			end else if (reg_ofs >= MTIME_OFS && reg_ofs < MTIME_OFS + 20'd8
					&& r.size == CLINT_REG_SIZE) begin
				ans.rdata = hi ? mtime_q[63:32] : mtime_q[31:0];
				if (stores) begin
					if (hi) begin
						mtime_q[63:32] = r.wdata;
					end else begin
						mtime_q[31:0] = r.wdata;
					end
					rearm_timer();
				end
			end else if (reg_ofs == MSIP_OFS && r.size == CLINT_REG_SIZE) begin
				// Software interrupts are not modeled: only a zero may be stored.
				if (stores && r.wdata != 32'd0) begin
					ans.status = ST_UNSUP;
				end
			end else begin
				ans.status = access_fault(r.op);
			end
		end else begin
			ram_ofs = r.addr - RAM_START;
			if (ram_ofs >= RAM_SPAN || {60'd0, r.size} > RAM_SPAN - ram_ofs) begin
				ans.status = access_fault(r.op);
			end else begin
				ans.status = ST_RAM;
				ans.ofs = ram_ofs[25:0];
			end
		end
		ans.pend = irq_pending;
	endtask

	task automatic send_item(input access_row_t r);
		bus_answer_t ans;
		while (!calm && $urandom_range(0, 99) < 7) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r.op;
		s_axis_tdata  <= {4'd0, r.wdata, r.size, r.addr};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		predict_answer(r, ans);
		if (r.typed) begin
			ans.status = r.status;
			ans.ofs = r.ofs;
			ans.rdata = r.rdata;
			ans.pend = r.pend;
		end
		answers_due.push_back(ans);
	endtask

	// Most random items are ticks and timer register accesses with small values,
	// so that compares really fire; the rest hit RAM, miss in the CLINT or are noise.
	task automatic random_row(output access_row_t r);
		int          kind;
		logic [19:0] reg_ofs;
		logic [31:0] pick;
		kind = $urandom_range(0, 99);
		r = stim($urandom_range(0, 3), {$urandom, $urandom}, 4'd1 << $urandom_range(0, 3),
			$urandom);
		if (kind < 30) begin
			r.op = OP_TICK;
		end else if (kind < 58) begin
			case ($urandom_range(0, 4))
				0:       reg_ofs = MSIP_OFS;
				1:       reg_ofs = MTIMECMP_OFS;
				2:       reg_ofs = MTIMECMP_OFS + 20'd4;
				3:       reg_ofs = MTIME_OFS;
				default: reg_ofs = MTIME_OFS + 20'd4;
			endcase
			r.size = CLINT_REG_SIZE;
			r.addr = CLINT_BASE | {44'd0, reg_ofs};
			if ($urandom_range(0, 3) != 0) begin
				r.wdata = reg_ofs[2] ? 32'd0 : $urandom_range(0, 24);
			end
		end else if (kind < 76) begin
			if ($urandom_range(0, 4) == 0) begin
				pick = 32'h0400_0000 - $urandom_range(1, 16);
			end else begin
				pick = $urandom_range(0, 32'h03FF_FFFF);
				pick = pick & ~({28'd0, r.size} - 32'd1);
			end
			r.addr = RAM_START + {32'd0, pick};
		end else if (kind < 86) begin
			r.addr = CLINT_BASE | {44'd0, 20'($urandom)};
			r.size = $urandom_range(0, 15);
		end else begin
			r.op = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 4) : $urandom_range(5, 7);
			r.size = $urandom_range(0, 15);
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("clint_timer_bus_decoder_tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		bus_answer_t ans;
		if (arst_n) begin
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
			if (m_axis_tvalid && m_axis_tready) begin
				if (answers_due.size() == 0) begin
					$error("result item with no expectation waiting");
					mismatches++;
				end else begin
					ans = answers_due.pop_front();
					if (m_axis_tuser !== ans.status) begin
						$error("status: expected %0d, got %0d", ans.status, m_axis_tuser);
						mismatches++;
					end
					if (m_axis_tdata[25:0] !== ans.ofs) begin
						$error("ram_offset: expected %h, got %h", ans.ofs, m_axis_tdata[25:0]);
						mismatches++;
					end
					if (m_axis_tdata[57:26] !== ans.rdata) begin
						$error("rdata: expected %h, got %h", ans.rdata, m_axis_tdata[57:26]);
						mismatches++;
					end
					if (m_axis_tdata[58] !== ans.pend) begin
						$error("timer_pending: expected %0d, got %0d", ans.pend,
							m_axis_tdata[58]);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		access_row_t r;
		// Fresh state: mtime and msip read zero and nothing is pending.
		directed_rows.push_back(stim(OP_READ, CLINT_BASE + MTIME_OFS, 4, 0,
			1, ST_CLINT, 0, 0, 0));
		directed_rows.push_back(stim(OP_READ, CLINT_BASE + MSIP_OFS, 4, 0,
			1, ST_CLINT, 0, 0, 0));
		directed_rows.push_back(stim(OP_WRITE, CLINT_BASE + MSIP_OFS, 4, 32'hFFFF_FFFF,
			1, ST_UNSUP, 0, 0, 0));
		directed_rows.push_back(stim(OP_ATOMIC, CLINT_BASE + MSIP_OFS, 4, 0,
			1, ST_CLINT, 0, 0, 0));
		directed_rows.push_back(stim(OP_READ, RAM_START + 1, 2, 0, 1, ST_LMIS, 0, 0, 0));
		directed_rows.push_back(stim(OP_WRITE, RAM_START + 2, 4, 0, 1, ST_SMIS, 0, 0, 0));
		directed_rows.push_back(stim(OP_ATOMIC, RAM_START + 4, 8, 0, 1, ST_SMIS, 0, 0, 0));
		// A misaligned fetch is not flagged and decodes normally.
		directed_rows.push_back(stim(OP_FETCH, RAM_START + 1, 4, 0, 1, ST_RAM, 1, 0, 0));
		directed_rows.push_back(stim(OP_READ, RAM_START, 8, 0, 1, ST_RAM, 0, 0, 0));
		directed_rows.push_back(stim(OP_READ, RAM_START + RAM_SPAN - 8, 8, 0,
			1, ST_RAM, 26'h3FF_FFF8, 0, 0));
		directed_rows.push_back(stim(OP_READ, RAM_START + RAM_SPAN, 1, 0, 1, ST_LFLT, 0, 0, 0));
		directed_rows.push_back(stim(OP_FETCH, 64'd0, 4, 0, 1, ST_XFLT, 0, 0, 0));
		directed_rows.push_back(stim(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFF8, 8, 32'hFFFF_FFFF,
			1, ST_SFLT, 0, 0, 0));
		directed_rows.push_back(stim(OP_READ, CLINT_BASE + 8, 4, 0, 1, ST_LFLT, 0, 0, 0));
		directed_rows.push_back(stim(OP_READ, CLINT_BASE + MTIME_OFS, 8, 0,
			1, ST_LFLT, 0, 0, 0));
		directed_rows.push_back(stim(3'd5, RAM_START, 4, 0, 1, ST_UNSUP, 0, 0, 0));
		directed_rows.push_back(stim(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 15, 32'hFFFF_FFFF,
			1, ST_UNSUP, 0, 0, 0));
		// Size zero masks every address bit.
		directed_rows.push_back(stim(OP_READ, RAM_START, 0, 0, 1, ST_LMIS, 0, 0, 0));
		directed_rows.push_back(stim(OP_READ, RAM_START + 4, 3, 0));
		// Arm a compare three ticks ahead, then let the ticks reach it.
		directed_rows.push_back(stim(OP_WRITE, CLINT_BASE + MTIMECMP_OFS, 4, 3));
		directed_rows.push_back(stim(OP_TICK, 0, 0, 0));
		directed_rows.push_back(stim(OP_TICK, 0, 0, 0));
		directed_rows.push_back(stim(OP_TICK, 0, 0, 0));
		directed_rows.push_back(stim(OP_ATOMIC, CLINT_BASE + MTIME_OFS + 4, 4, 32'hFFFF_FFFF));
		directed_rows.push_back(stim(OP_WRITE, CLINT_BASE + MTIME_OFS, 4, 32'hFFFF_FFFF));
		// The counter wraps to zero while the compare is disarmed.
		directed_rows.push_back(stim(OP_TICK, 0, 0, 0));
		directed_rows.push_back(stim(OP_WRITE, CLINT_BASE + MTIMECMP_OFS + 4, 4, 32'hFFFF_FFFF));
		directed_rows.push_back(stim(OP_FETCH, CLINT_BASE + MTIMECMP_OFS + 5, 4, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i]);
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			random_row(r);
			send_item(r);
		end
		s_axis_tvalid <= 1'b0;
		while (answers_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("clint_timer_bus_decoder_tb OK");
		end else begin
			$display("clint_timer_bus_decoder_tb NOT OK");
		end
		$finish;
	end

endmodule
